/* src/gif_lzw_decoder_defines.svh */
// assertion helpers included by the engine rtl file
`ifndef GIF_LZW_DECODER_DEFINES_SVH
`define GIF_LZW_DECODER_DEFINES_SVH

// property must hold at every clock edge outside reset
`define GIFL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define GIFL_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* src/gifl_pkg.sv */
`timescale 1ns / 1ps
package gifl_pkg;
	localparam int DICT_ENTRIES_DEF     = 4096;
	localparam int PIXELS_PER_FETCH_DEF = 8;
	localparam int STACK_DEPTH          = 4096;
	localparam int STACK_AW             = 12;
	localparam logic [3:0] MAX_WIDTH    = 4'd12;
	localparam logic [3:0] MIN_SIZE_LO  = 4'd2;
	localparam logic [3:0] MIN_SIZE_HI  = 4'd8;

	localparam logic OP_FEED  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_END  = 2'd2;
	localparam logic [1:0] ST_BAD  = 2'd3;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_FA, S_FD, S_CHK, S_WA, S_WD, S_HEAD, S_POP, S_DONE
	} state_t;
endpackage

/* src/gifl_ram.sv */
`timescale 1ns / 1ps
module gifl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/gifl_front.sv */
`timescale 1ns / 1ps
module gifl_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  gifl_pkg::item_t in_item,
	output logic          q_valid,
	output gifl_pkg::item_t q_item,
	input  logic          q_take
);
	import gifl_pkg::*;

	// two-entry queue toward the decode engine
	item_t      slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_take && q_valid;
	assign q_item   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* src/gifl_engine.sv */
`timescale 1ns / 1ps
`include "gif_lzw_decoder_defines.svh"
module gifl_engine #(
	parameter int DICT_ENTRIES     = gifl_pkg::DICT_ENTRIES_DEF,
	parameter int PIXELS_PER_FETCH = gifl_pkg::PIXELS_PER_FETCH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [3:0]      cfg_wdata,
	input  logic            q_valid,
	input  gifl_pkg::item_t q_item,
	output logic            q_take,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [63:0]     pixels,
	output logic [3:0]      pixel_count,
	output logic [1:0]      status,
	output logic            more_pending
);
	import gifl_pkg::*;

	localparam int DAW = $clog2(DICT_ENTRIES);
	localparam logic [12:0] DICT_N = 13'(DICT_ENTRIES);
	localparam logic [3:0]  PPF    = 4'(PIXELS_PER_FETCH);

	state_t state_q, state_d;
	logic        op_q;
	logic [1:0]  st_q;
	logic [19:0] acc_q;
	logic [4:0]  bits_q;
	logic [3:0]  width_q, min_q;
	logic [12:0] nf_q, level_q;
	logic [11:0] prev_q, code_q, c_q;
	logic        kwk_q, ended_q;
	logic [7:0]  fp_q;
	logic [3:0]  cnt_q;
	logic [2:0]  slot_q;
	logic        rdv_q;
	logic [63:0] pix_q;

	logic        out_v_q;
	logic [63:0] out_pix_q;
	logic [3:0]  out_cnt_q;
	logic [1:0]  out_st_q;
	logic        out_more_q;

	// derived codes
	logic [12:0] roots, mask, nf_inc;
	logic [11:0] clear_c, end_c, code_w;
	logic        known_w, kwk_w, code_rdy, stk_room, add_ok, pop_go, out_free;
	logic [3:0]  min_sat;

	assign roots    = 13'(1) << min_q;
	assign clear_c  = roots[11:0];
	assign end_c    = clear_c + 12'd1;
	assign mask     = (13'(1) << width_q) - 13'd1;
	assign code_w   = acc_q[11:0] & mask[11:0];
	assign known_w  = ({1'b0, code_w} < roots) ||
		({1'b0, code_w} >= roots + 13'd2 && {1'b0, code_w} < nf_q &&
		{1'b0, code_w} < DICT_N);
	assign kwk_w    = !known_w && {1'b0, code_w} == nf_q && prev_q != clear_c &&
		nf_q < DICT_N;
	assign code_rdy = !ended_q && ({1'b0, bits_q} >= {2'b0, width_q});
	assign stk_room = !level_q[12];
	assign add_ok   = prev_q != clear_c && nf_q < DICT_N;
	assign nf_inc   = nf_q + 13'd1;
	assign pop_go   = cnt_q < PPF && level_q != 13'd0;
	assign out_free = !out_v_q || !out_stall;
	assign min_sat  = (cfg_wdata < MIN_SIZE_LO) ? MIN_SIZE_LO :
		(cfg_wdata > MIN_SIZE_HI) ? MIN_SIZE_HI : cfg_wdata;

	// dictionary and stack memories
	logic             d_we, s_we;
	logic [DAW-1:0]   d_raddr;
	logic [11:0]      pre_rd;
	logic [7:0]       suf_rd, fst_rd, stk_rd, s_wdata;
	logic [STACK_AW-1:0] s_raddr;

	gifl_ram #(.WIDTH(12), .DEPTH(DICT_ENTRIES)) u_prefix (
		.clk(clk), .we(d_we), .waddr(nf_q[DAW-1:0]), .wdata(prev_q),
		.raddr(d_raddr), .rdata(pre_rd));
	gifl_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_suffix (
		.clk(clk), .we(d_we), .waddr(nf_q[DAW-1:0]), .wdata(c_q[7:0]),
		.raddr(d_raddr), .rdata(suf_rd));
	gifl_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_first (
		.clk(clk), .we(d_we), .waddr(nf_q[DAW-1:0]), .wdata(fp_q),
		.raddr(d_raddr), .rdata(fst_rd));
	gifl_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(s_we), .waddr(level_q[STACK_AW-1:0]), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(stk_rd));

	assign s_raddr = 12'(level_q - 13'd1);

	always_comb begin
		state_d = state_q;
		q_take  = 1'b0;
		d_we    = 1'b0;
		s_we    = 1'b0;
		s_wdata = c_q[7:0];
		d_raddr = c_q[DAW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_take = 1'b1;
					if (q_item.operation == OP_FEED) begin
						if (ended_q || level_q != 13'd0 || code_rdy) begin
							state_d = S_DONE;
						end else if ({1'b0, bits_q} + 6'd8 >= {2'b0, width_q}) begin
							state_d = S_DEC;
						end else begin
							state_d = S_DONE;
						end
					end else begin
						state_d = (level_q == 13'd0 && code_rdy) ? S_DEC : S_POP;
					end
				end
			end
			S_DEC: begin
				if (code_w == clear_c || code_w == end_c || (!known_w && !kwk_w)) begin
					state_d = op_q ? S_POP : S_DONE;
				end else begin
					state_d = S_FA;
				end
			end
			S_FA: begin
				d_raddr = prev_q[DAW-1:0];
				state_d = S_FD;
			end
			S_FD: begin
				s_we    = kwk_q;
				s_wdata = ({1'b0, prev_q} < roots) ? prev_q[7:0] : fst_rd;
				state_d = S_CHK;
			end
			S_CHK: state_d = ({1'b0, c_q} >= roots + 13'd2) ? S_WA : S_HEAD;
			S_WA: state_d = S_WD;
			S_WD: begin
				s_we    = stk_room;
				s_wdata = suf_rd;
				state_d = S_CHK;
			end
			S_HEAD: begin
				s_we    = stk_room;
				d_we    = add_ok;
				state_d = op_q ? S_POP : S_DONE;
			end
			S_POP: begin
				if (!pop_go && !rdv_q) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			min_q   <= MIN_SIZE_HI;
			acc_q   <= '0;
			bits_q  <= '0;
			width_q <= MIN_SIZE_HI + 4'd1;
			nf_q    <= (13'(1) << MIN_SIZE_HI) + 13'd2;
			prev_q  <= 12'(13'(1) << MIN_SIZE_HI);
			level_q <= '0;
			ended_q <= 1'b0;
			out_v_q <= 1'b0;
			rdv_q   <= 1'b0;
		end else if (cfg_we) begin
			// register write restarts the decode engine; the front queue and the output register keep their contents
			state_q <= S_IDLE;
			min_q   <= min_sat;
			acc_q   <= '0;
			bits_q  <= '0;
			width_q <= min_sat + 4'd1;
			nf_q    <= (13'(1) << min_sat) + 13'd2;
			prev_q  <= 12'(13'(1) << min_sat);
			level_q <= '0;
			ended_q <= 1'b0;
			rdv_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						op_q  <= q_item.operation;
						st_q  <= ST_OK;
						cnt_q <= '0;
						pix_q <= '0;
						rdv_q <= 1'b0;
						if (q_item.operation == OP_FEED) begin
							if (ended_q) begin
								st_q <= ST_END;
							end else if (level_q != 13'd0 || code_rdy) begin
								st_q <= ST_BUSY;
							end else begin
								acc_q  <= acc_q | (20'(q_item.data_byte) << bits_q);
								bits_q <= bits_q + 5'd8;
							end
						end
					end
				end
				S_DEC: begin
					acc_q  <= acc_q >> width_q;
					bits_q <= bits_q - 5'(width_q);
					code_q <= code_w;
					kwk_q  <= kwk_w;
					if (code_w == clear_c) begin
						width_q <= min_q + 4'd1;
						nf_q    <= roots + 13'd2;
						prev_q  <= clear_c;
					end else if (code_w == end_c) begin
						ended_q <= 1'b1;
						acc_q   <= '0;
						bits_q  <= '0;
						st_q    <= ST_END;
					end else if (!known_w && !kwk_w) begin
						st_q <= ST_BAD;
					end
				end
				S_FD: begin
					fp_q    <= s_wdata;
					level_q <= kwk_q ? 13'd1 : 13'd0;
					c_q     <= kwk_q ? prev_q : code_q;
				end
				S_WD: begin
					if (stk_room) level_q <= level_q + 13'd1;
					c_q <= pre_rd;
				end
				S_HEAD: begin
					if (stk_room) level_q <= level_q + 13'd1;
					if (add_ok) begin
						nf_q <= nf_inc;
						if (nf_inc >= (13'(1) << width_q) && nf_inc < DICT_N &&
							width_q < MAX_WIDTH) begin
							width_q <= width_q + 4'd1;
						end
					end
					prev_q <= code_q;
				end
				S_POP: begin
					if (rdv_q) pix_q[{slot_q, 3'b000} +: 8] <= stk_rd;
					rdv_q  <= pop_go;
					slot_q <= cnt_q[2:0];
					if (pop_go) begin
						level_q <= level_q - 13'd1;
						cnt_q   <= cnt_q + 4'd1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_pix_q  <= pix_q;
						out_cnt_q  <= cnt_q;
						out_st_q   <= (op_q == OP_FETCH && ended_q && cnt_q == 4'd0) ?
							ST_END : st_q;
						out_more_q <= level_q != 13'd0 || code_rdy;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid    = out_v_q;
	assign pixels       = out_pix_q;
	assign pixel_count  = out_cnt_q;
	assign status       = out_st_q;
	assign more_pending = out_more_q;

	`GIFL_ASSERT(a_cnt_cap, out_v_q |-> out_cnt_q <= PPF, "pixel count above fetch size")
	`GIFL_ASSERT(a_width_cap, width_q <= MAX_WIDTH, "code width beyond twelve bits")
	`GIFL_NEVER(a_dict_walk_level, d_we && s_we && !stk_room, "push into a full stack")
	`GIFL_ASSERT(a_pop_only, (state_q == S_IDLE) |=> level_q <= $past(level_q) || cfg_we ||
		$past(cfg_we), "stack grew without a decode")
endmodule

/* src/gif_lzw_decoder.sv */
`timescale 1ns / 1ps
// gif lzw decoder, pulled pixel output, one result per item
// a feed takes its byte when the stack is empty and no code waits, then decodes a code once enough
// bits are held; a clear, end or invalid code ends there, any other code walks the prefix chain onto
// the stack; a fetch pops up to PIXELS_PER_FETCH pixels, first decoding a ready code if none are stacked
// the engine takes one item at a time; reset (arst_n, or a min_code_size write clamped to 2..8)
// sets min size 8 on arst_n, else the written one; empty accumulator and stack, fresh dictionary
module gif_lzw_decoder #(
	parameter int DICT_ENTRIES     = gifl_pkg::DICT_ENTRIES_DEF,
	parameter int PIXELS_PER_FETCH = gifl_pkg::PIXELS_PER_FETCH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: min_code_size
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] pixels,
	output logic [3:0]  pixel_count,
	output logic [1:0]  status,
	output logic        more_pending
);
	import gifl_pkg::*;

	item_t in_item, q_item;
	logic  q_valid, q_take;

	assign in_item.operation = operation;
	assign in_item.data_byte = data_byte;

	// front: takes each transfer into a short queue so the engine can stall on its own
	gifl_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.q_valid(q_valid), .q_item(q_item), .q_take(q_take)
	);

	// back: code extraction, dictionary walk, stack drain and the output register
	gifl_engine #(
		.DICT_ENTRIES(DICT_ENTRIES),
		.PIXELS_PER_FETCH(PIXELS_PER_FETCH)
	) u_engine (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.q_valid(q_valid), .q_item(q_item), .q_take(q_take),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixels(pixels), .pixel_count(pixel_count),
		.status(status), .more_pending(more_pending)
	);
endmodule
